// ===== src/mcg_pkg.sv =====
// ----------------------------------------------------------------------------
// mcg_pkg
// Shared widths, tables, codes and types of the month calendar grid generator.
// ----------------------------------------------------------------------------
package mcg_pkg;

    // Field widths
    localparam int MONTH_W = 4;
    localparam int YEAR_W  = 14;
    localparam int DAY_W   = 5;
    localparam int ROW_W   = 3;
    localparam int COL_W   = 3;
    localparam int PIX_W   = 10;
    localparam int KIND_W  = 2;
    localparam int ORG_W   = 8;
    localparam int CELL_W  = 6;

    // APB port
    localparam int APB_AW = 4;
    localparam int APB_DW = 32;

    // Register indexes
    localparam logic [1:0] REG_ORIGIN_X  = 2'd0;
    localparam logic [1:0] REG_ORIGIN_Y  = 2'd1;
    localparam logic [1:0] REG_COL_PITCH = 2'd2;
    localparam logic [1:0] REG_ROW_PITCH = 2'd3;

    // Register reset values
    localparam logic [ORG_W-1:0]  ORIGIN_RST = '0;
    localparam logic [CELL_W-1:0] CELL_RST   = 6'd13;

    // Cell kind codes
    localparam logic [KIND_W-1:0] KIND_WEEKDAY  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_SUNDAY   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_SATURDAY = 2'd2;
    localparam logic [KIND_W-1:0] KIND_TODAY    = 2'd3;

    // Grid geometry
    localparam logic [PIX_W-1:0] LEFT_DX   = 10'd6;
    localparam logic [PIX_W-1:0] HEADER_DY = 10'd22;
    localparam logic [COL_W-1:0] LAST_COL  = 3'd6;

    // Calendar arithmetic
    localparam int              NUM_MONTHS  = 12;
    localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd0;
    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_MAX = 4'd11;
    localparam logic [DAY_W-1:0]   LEAP_FEB_LEN = 5'd29;
    localparam logic [14:0]     CYCLE_YEARS = 15'd400;
    localparam logic [12:0]     RECIP_100   = 13'd5243;  // 2^19 / 100, rounded up
    localparam int              RECIP_SHIFT = 19;
    localparam int              QUOT_W      = 8;
    localparam int              REM_W       = 7;
    localparam logic [REM_W-1:0] CENTURY_LAST = 7'd99;

    // Days per month, leap February patched separately
    localparam logic [DAY_W-1:0] MONTH_LEN [NUM_MONTHS] = '{
        5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
        5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
    };

    // 1 + 13*(m+1)/5 of the congruence, m shifted so March is 3
    localparam logic [5:0] ZELLER_MTERM [NUM_MONTHS] = '{
        6'd37, 6'd40, 6'd11, 6'd14, 6'd16, 6'd19,
        6'd21, 6'd24, 6'd27, 6'd29, 6'd32, 6'd34
    };

    // Month summary handed from the date unit to the cell walker
    typedef struct packed {
        logic [COL_W-1:0] first;
        logic [DAY_W-1:0] len;
        logic [DAY_W-1:0] today;
    } t_month_info;

    // Grid configuration
    typedef struct packed {
        logic [ORG_W-1:0]  origin_x;
        logic [ORG_W-1:0]  origin_y;
        logic [CELL_W-1:0] col_pitch;
        logic [CELL_W-1:0] row_pitch;
    } t_grid_cfg;

endpackage

// ===== src/mcg_item_if.sv =====
// ----------------------------------------------------------------------------
// mcg_item_if
// Input channel: one month request per transaction.
// ----------------------------------------------------------------------------
interface mcg_item_if import mcg_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [MONTH_W-1:0]  month_index;
    logic [YEAR_W-1:0]   full_year;
    logic [DAY_W-1:0]    today_day;

    modport source (output valid, output month_index, output full_year,
                    output today_day, input ready);
    modport sink   (input valid, input month_index, input full_year,
                    input today_day, output ready);
endinterface

// ===== src/mcg_cell_if.sv =====
// ----------------------------------------------------------------------------
// mcg_cell_if
// Output channel: one calendar day cell per transaction.
// ----------------------------------------------------------------------------
interface mcg_cell_if import mcg_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [DAY_W-1:0]   day_number;
    logic [ROW_W-1:0]   week_row;
    logic [COL_W-1:0]   weekday_column;
    logic [PIX_W-1:0]   pixel_x;
    logic [PIX_W-1:0]   pixel_y;
    logic [KIND_W-1:0]  cell_kind;
    logic               last_cell;

    modport source (output valid, output day_number, output week_row,
                    output weekday_column, output pixel_x, output pixel_y,
                    output cell_kind, output last_cell, input ready);
    modport sink   (input valid, input day_number, input week_row,
                    input weekday_column, input pixel_x, input pixel_y,
                    input cell_kind, input last_cell, output ready);
endinterface

// ===== src/mcg_date_unit.sv =====
// ----------------------------------------------------------------------------
// mcg_date_unit
// Finds the month length and the weekday of the 1st. A small sequencer
// splits the year by 100, then runs the congruence terms one a cycle
// through a shared add-and-reduce-mod-7 unit.
// ----------------------------------------------------------------------------
module mcg_date_unit import mcg_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mcg_item_if.sink    i_item,
    input  logic        i_take,
    output logic        o_info_valid,
    output t_month_info o_info
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL  = 3'd1;
    localparam logic [2:0] ST_REM  = 3'd2;
    localparam logic [2:0] ST_ACC  = 3'd3;
    localparam logic [2:0] ST_HOLD = 3'd4;

    localparam logic [2:0] STEP_MONTH = 3'd0;
    localparam logic [2:0] STEP_K     = 3'd1;
    localparam logic [2:0] STEP_K4    = 3'd2;
    localparam logic [2:0] STEP_J4    = 3'd3;
    localparam logic [2:0] STEP_J5    = 3'd4;
    localparam logic [2:0] STEP_SHIFT = 3'd5;

    localparam logic [9:0] SUNDAY_SHIFT = 10'd6;

    // Reduce an 11-bit value mod 7 by folding octal digits (8 = 1 mod 7)
    function automatic logic [2:0] mod7(input logic [10:0] v);
        logic [4:0] s1;
        logic [3:0] s2;
        s1 = {2'b0, v[2:0]} + {2'b0, v[5:3]} + {2'b0, v[8:6]} + {3'b0, v[10:9]};
        s2 = {1'b0, s1[2:0]} + {2'b0, s1[4:3]};
        return (s2 >= 4'd7) ? 3'(s2 - 4'd7) : s2[2:0];
    endfunction

    logic [2:0]          r_state, n_state;
    logic [MONTH_W-1:0]  r_mon;
    logic [DAY_W-1:0]    r_today;
    logic [14:0]         r_y0;
    logic [27:0]         r_prod;
    logic [REM_W-1:0]    r_k;
    logic [QUOT_W-1:0]   r_j;
    logic                r_leap;
    logic [2:0]          r_step;
    logic [2:0]          r_acc;

    logic [QUOT_W-1:0]   quot;
    logic [14:0]         rem_wide;
    logic [REM_W-1:0]    rem;
    logic                leap;
    logic [9:0]          term;
    logic [10:0]         acc_sum;
    logic                accept;

    assign accept = i_item.valid && i_item.ready;

    // Quotient and remainder of the shifted year by 100
    assign quot     = r_prod[RECIP_SHIFT +: QUOT_W];
    assign rem_wide = r_y0 - (15'(quot) * 15'd100);
    assign rem      = rem_wide[REM_W-1:0];
    assign leap     = ((rem[1:0] == 2'b00) && (rem != '0))
                   || ((rem == '0) && (quot[1:0] == 2'b00));

    // Select the congruence term of this step
    always_comb begin
        unique case (r_step)
            STEP_MONTH: term = {4'b0, ZELLER_MTERM[r_mon]};
            STEP_K:     term = {3'b0, r_k};
            STEP_K4:    term = {5'b0, r_k[REM_W-1:2]};
            STEP_J4:    term = {4'b0, r_j[QUOT_W-1:2]};
            STEP_J5:    term = {r_j, 2'b00} + {2'b0, r_j};
            default:    term = SUNDAY_SHIFT;
        endcase
    end

    // Shared add-and-reduce unit
    assign acc_sum = {8'b0, r_acc} + {1'b0, term};

    // Sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept && (i_item.month_index <= MONTH_MAX)) n_state = ST_MUL;
            end
            ST_MUL:  n_state = ST_REM;
            ST_REM:  n_state = ST_ACC;
            ST_ACC: begin
                if (r_step == STEP_SHIFT) n_state = ST_HOLD;
            end
            ST_HOLD: begin
                if (i_take) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    r_mon   <= i_item.month_index;
                    r_today <= i_item.today_day;
                    r_y0    <= {1'b0, i_item.full_year} + CYCLE_YEARS;
                end
            end
            ST_MUL: begin
                r_prod <= {13'b0, r_y0} * {15'b0, RECIP_100};
            end
            ST_REM: begin
                r_leap <= leap;
                r_step <= STEP_MONTH;
                r_acc  <= '0;
                // January and February count in the year before
                if (r_mon <= MONTH_FEB) begin
                    if (rem == '0) begin
                        r_k <= CENTURY_LAST;
                        r_j <= quot - 1'b1;
                    end else begin
                        r_k <= rem - 1'b1;
                        r_j <= quot;
                    end
                end else begin
                    r_k <= rem;
                    r_j <= quot;
                end
            end
            ST_ACC: begin
                r_acc  <= mod7(acc_sum);
                r_step <= r_step + 1'b1;
            end
            default: begin
            end
        endcase
    end

    assign i_item.ready  = (r_state == ST_IDLE);
    assign o_info_valid  = (r_state == ST_HOLD);
    assign o_info.first  = r_acc;
    assign o_info.len    = ((r_mon == MONTH_FEB) && r_leap) ? LEAP_FEB_LEN
                                                            : MONTH_LEN[r_mon];
    assign o_info.today  = r_today;

endmodule

// ===== src/mcg_cell_walker.sv =====
// ----------------------------------------------------------------------------
// mcg_cell_walker
// Walks the days of one month, one cell a cycle unless stalled, stepping row,
// column and pixel position by additions, into a registered output stage.
// ----------------------------------------------------------------------------
module mcg_cell_walker import mcg_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_info_valid,
    input  t_month_info i_info,
    input  t_grid_cfg   i_cfg,
    output logic        o_take,
    mcg_cell_if.source  o_cell
);

    logic               r_busy;
    logic [DAY_W-1:0]   r_day;
    logic [ROW_W-1:0]   r_row;
    logic [COL_W-1:0]   r_col;
    logic [PIX_W-1:0]   r_px;
    logic [PIX_W-1:0]   r_py;
    logic [DAY_W-1:0]   r_len;
    logic [DAY_W-1:0]   r_today;

    logic               r_ov;
    logic [DAY_W-1:0]   r_o_day;
    logic [ROW_W-1:0]   r_o_row;
    logic [COL_W-1:0]   r_o_col;
    logic [PIX_W-1:0]   r_o_px;
    logic [PIX_W-1:0]   r_o_py;
    logic [KIND_W-1:0]  r_o_kind;
    logic               r_o_last;

    logic [PIX_W-1:0]   px_left;
    logic [PIX_W-1:0]   px_first;
    logic [PIX_W-1:0]   py_first;
    logic [8:0]         first_off;
    logic [KIND_W-1:0]  kind;
    logic               is_last;
    logic               emit;

    assign o_take = i_info_valid && !r_busy;
    assign emit   = r_busy && (!r_ov || o_cell.ready);

    // Start positions of the month
    assign px_left   = {2'b0, i_cfg.origin_x} + LEFT_DX;
    assign first_off = {6'b0, i_info.first} * {3'b0, i_cfg.col_pitch};
    assign px_first  = px_left + {1'b0, first_off};
    assign py_first  = {2'b0, i_cfg.origin_y} + HEADER_DY + {4'b0, i_cfg.row_pitch};

    assign is_last = (r_day == r_len);

    // Classify the current cell, today first
    always_comb begin
        priority if (r_day == r_today) begin
            kind = KIND_TODAY;
        end else if (r_col == '0) begin
            kind = KIND_SUNDAY;
        end else if (r_col == LAST_COL) begin
            kind = KIND_SATURDAY;
        end else begin
            kind = KIND_WEEKDAY;
        end
    end

    // Control: busy flag and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_ov   <= 1'b0;
        end else begin
            if (o_take) begin
                r_busy <= 1'b1;
            end else if (emit && is_last) begin
                r_busy <= 1'b0;
            end
            if (emit) begin
                r_ov <= 1'b1;
            end else if (o_cell.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    // Walker position: load on a new month, advance on each emitted cell
    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_day   <= 5'd1;
            r_row   <= '0;
            r_col   <= i_info.first;
            r_px    <= px_first;
            r_py    <= py_first;
            r_len   <= i_info.len;
            r_today <= i_info.today;
        end else if (emit) begin
            r_day <= r_day + 1'b1;
            if (r_col == LAST_COL) begin
                r_col <= '0;
                r_row <= r_row + 1'b1;
                r_px  <= px_left;
                r_py  <= r_py + {4'b0, i_cfg.row_pitch};
            end else begin
                r_col <= r_col + 1'b1;
                r_px  <= r_px + {4'b0, i_cfg.col_pitch};
            end
        end
    end

    // Output stage payload
    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_o_day  <= r_day;
            r_o_row  <= r_row;
            r_o_col  <= r_col;
            r_o_px   <= r_px;
            r_o_py   <= r_py;
            r_o_kind <= kind;
            r_o_last <= is_last;
        end
    end

    assign o_cell.valid          = r_ov;
    assign o_cell.day_number     = r_o_day;
    assign o_cell.week_row       = r_o_row;
    assign o_cell.weekday_column = r_o_col;
    assign o_cell.pixel_x        = r_o_px;
    assign o_cell.pixel_y        = r_o_py;
    assign o_cell.cell_kind      = r_o_kind;
    assign o_cell.last_cell      = r_o_last;

endmodule

// ===== src/month_calendar_grid_generator_unit.sv =====
// ----------------------------------------------------------------------------
// month_calendar_grid_generator_unit
// Month calendar grid generator: one request in, one cell per day out.
// ----------------------------------------------------------------------------
// Usage:
//   i_item takes a month (0 January), a Gregorian year and today's day.
//   o_cell returns one transaction per day of that month, in day order,
//   with row, column, pixel position and kind; last_cell marks the end.
//   A month index above 11 is consumed and yields no cells.
//   Grid origin and cell size come from the APB registers; write them only
//   while no request is in flight.
// Timing:
//   After acceptance the date unit runs a multiply by the reciprocal of
//   100, a remainder step and six passes of the shared mod-7 accumulator,
//   then holds its result until the cell walker takes it. Each cell
//   passes through the walker's registered output stage.
//   The cell walker sends one cell a cycle while o_cell is not stalled,
//   28 to 31 cells per month, and can take the next month in the cycle
//   after it emits its last cell. The date unit accepts the next request once
//   it has handed its result over, so it can work ahead while cells flow.
// Reset and stall:
//   Reset empties both stages and restores the register defaults.
//   A stalled o_cell holds the current cell and freezes the walker.
// ----------------------------------------------------------------------------
module month_calendar_grid_generator_unit import mcg_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    mcg_item_if.sink           i_item,
    mcg_cell_if.source         o_cell,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [APB_AW-1:0]  paddr,
    input  logic [APB_DW-1:0]  pwdata,
    output logic [APB_DW-1:0]  prdata,
    output logic               pready
);

    logic [ORG_W-1:0]  r_origin_x;
    logic [ORG_W-1:0]  r_origin_y;
    logic [CELL_W-1:0] r_col_pitch;
    logic [CELL_W-1:0] r_row_pitch;

    logic        cfg_write;
    logic [1:0]  reg_idx;
    logic        info_valid;
    logic        take;
    t_month_info info;
    t_grid_cfg   cfg;

    // Configuration registers
    assign pready    = 1'b1;
    assign reg_idx   = paddr[APB_AW-1:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_origin_x  <= ORIGIN_RST;
            r_origin_y  <= ORIGIN_RST;
            r_col_pitch <= CELL_RST;
            r_row_pitch <= CELL_RST;
        end else if (cfg_write) begin
            unique case (reg_idx)
                REG_ORIGIN_X:  r_origin_x  <= pwdata[ORG_W-1:0];
                REG_ORIGIN_Y:  r_origin_y  <= pwdata[ORG_W-1:0];
                REG_COL_PITCH: r_col_pitch <= pwdata[CELL_W-1:0];
                REG_ROW_PITCH: r_row_pitch <= pwdata[CELL_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Register readback
    always_comb begin
        unique case (reg_idx)
            REG_ORIGIN_X:  prdata = {24'b0, r_origin_x};
            REG_ORIGIN_Y:  prdata = {24'b0, r_origin_y};
            REG_COL_PITCH: prdata = {26'b0, r_col_pitch};
            REG_ROW_PITCH: prdata = {26'b0, r_row_pitch};
            default:       prdata = '0;
        endcase
    end

    assign cfg.origin_x  = r_origin_x;
    assign cfg.origin_y  = r_origin_y;
    assign cfg.col_pitch = r_col_pitch;
    assign cfg.row_pitch = r_row_pitch;

    // Month length and first weekday
    mcg_date_unit u_date (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item       (i_item),
        .i_take       (take),
        .o_info_valid (info_valid),
        .o_info       (info)
    );

    // Day cells
    mcg_cell_walker u_walker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_info_valid (info_valid),
        .i_info       (info),
        .i_cfg        (cfg),
        .o_take       (take),
        .o_cell       (o_cell)
    );

    // A final cell always closes a month of 28 to 31 days
    a_last_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cell.valid && o_cell.last_cell)
            |-> (o_cell.day_number >= 5'd28 && o_cell.day_number <= 5'd31))
        else $error("last cell outside 28..31");

    // Cells stay on the six-row, seven-column grid
    a_grid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cell.valid |-> (o_cell.weekday_column <= LAST_COL && o_cell.week_row <= 3'd5))
        else $error("cell off the grid");

    // Sunday kind sits in the first column
    a_sunday: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cell.valid && o_cell.cell_kind == KIND_SUNDAY) |-> (o_cell.weekday_column == '0))
        else $error("sunday kind off column 0");

    // A handover to the walker only happens from a finished date result
    a_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take |-> (info_valid && !i_item.ready))
        else $error("handover without date result");

endmodule

// ===== tb/sv/month_cell_checker.sv =====
// ----------------------------------------------------------------------------
// month_cell_checker
// Watches the month request and day cell channels and the register port,
// works out the cells that each accepted month must produce, and compares
// every accepted cell field by field with the oldest cell still owed.
// ----------------------------------------------------------------------------
module month_cell_checker import mcg_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    mcg_item_if                item_bus,
    mcg_cell_if                cell_bus,
    input  logic               i_psel,
    input  logic               i_penable,
    input  logic               i_pwrite,
    input  logic [APB_AW-1:0]  i_paddr,
    input  logic [APB_DW-1:0]  i_pwdata,
    input  logic               i_pready,
    output int                 o_cells_pending,
    output int                 o_fail_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [DAY_W-1:0]  day_number;
        logic [ROW_W-1:0]  week_row;
        logic [COL_W-1:0]  weekday_column;
        logic [PIX_W-1:0]  pixel_x;
        logic [PIX_W-1:0]  pixel_y;
        logic [KIND_W-1:0] cell_kind;
        logic              last_cell;
    } t_day_cell;

    t_day_cell owed_cells[$];
    t_grid_cfg grid;
    int        mismatches = 0;

    assign o_fail_count = mismatches;

    // Report one field that differs from its prediction
    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    // Append the cells of one month to the owed list
    function automatic void predict_month(input logic [MONTH_W-1:0] mon,
                                          input logic [YEAR_W-1:0]  year,
                                          input logic [DAY_W-1:0]   today);
        int unsigned yr, y, m, k, j, h, len, first, pos, row, col, px, py;
        bit          leap;
        t_day_cell   c;
        if (mon > MONTH_MAX)
            return;
        yr   = year;
        leap = ((yr % 4 == 0) && (yr % 100 != 0)) || (yr % 400 == 0);
        len  = MONTH_LEN[mon];
        if (mon == MONTH_FEB && leap)
            len = LEAP_FEB_LEN;

        // Zeller on a year pushed one cycle up, January and February as
        // months 13 and 14 of the year before; result remapped to Sunday 0
        y = yr + 400;
        m = mon + 1;
        if (mon < 2) begin
            m = m + 12;
            y = y - 1;
        end
        k     = y % 100;
        j     = y / 100;
        h     = (1 + (13 * (m + 1)) / 5 + k + k / 4 + j / 4 + 5 * j) % 7;
        first = (h + 6) % 7;

        for (int unsigned d = 1; d <= len; d++) begin
            pos = first + d - 1;
            row = pos / 7;
            col = pos % 7;
            px  = grid.origin_x + 6 + col * grid.col_pitch;
            py  = grid.origin_y + 22 + (row + 1) * grid.row_pitch;
            c.day_number     = d[DAY_W-1:0];
            c.week_row       = row[ROW_W-1:0];
            c.weekday_column = col[COL_W-1:0];
            c.pixel_x        = px[PIX_W-1:0];
            c.pixel_y        = py[PIX_W-1:0];
            if (d == today)
                c.cell_kind = KIND_TODAY;
            else if (col == 0)
                c.cell_kind = KIND_SUNDAY;
            else if (col == LAST_COL)
                c.cell_kind = KIND_SATURDAY;
            else
                c.cell_kind = KIND_WEEKDAY;
            c.last_cell = (d == len);
            owed_cells.push_back(c);
        end
    endfunction

    // Track registers, check cells, then predict new months
    always @(posedge i_clk) begin
        t_day_cell want;
        if (!i_rst_n) begin
            grid = '{ORIGIN_RST, ORIGIN_RST, CELL_RST, CELL_RST};
            owed_cells.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[APB_AW-1:2])
                    REG_ORIGIN_X:  grid.origin_x  = i_pwdata[ORG_W-1:0];
                    REG_ORIGIN_Y:  grid.origin_y  = i_pwdata[ORG_W-1:0];
                    REG_COL_PITCH: grid.col_pitch = i_pwdata[CELL_W-1:0];
                    REG_ROW_PITCH: grid.row_pitch = i_pwdata[CELL_W-1:0];
                    default: ;
                endcase
            end
            if (cell_bus.valid && cell_bus.ready) begin
                if (owed_cells.size() == 0) begin
                    $error("day cell transaction with none expected: day %0d",
                           cell_bus.day_number);
                    mismatches++;
                end else begin
                    want = owed_cells.pop_front();
                    check_field("day_number", want.day_number, cell_bus.day_number);
                    check_field("week_row", want.week_row, cell_bus.week_row);
                    check_field("weekday_column", want.weekday_column,
                                cell_bus.weekday_column);
                    check_field("pixel_x", want.pixel_x, cell_bus.pixel_x);
                    check_field("pixel_y", want.pixel_y, cell_bus.pixel_y);
                    check_field("cell_kind", want.cell_kind, cell_bus.cell_kind);
                    check_field("last_cell", want.last_cell, cell_bus.last_cell);
                end
            end
            if (item_bus.valid && item_bus.ready)
                predict_month(item_bus.month_index, item_bus.full_year,
                              item_bus.today_day);
        end
        o_cells_pending <= owed_cells.size();
    end

endmodule

// ===== tb/sv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Drives month requests and grid register writes into the calendar grid
// generator, throttles its cell output at random with one long hold-off,
// and reports the verdict from the failure count of the cell checker.
// ----------------------------------------------------------------------------
module testbench import mcg_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RAND_PHASES      = 5;
    localparam int MONTHS_PER_PHASE = 67;
    localparam int DRAIN_CYCLES     = 24;
    localparam int LONG_HOLD_AT     = 1800;
    localparam int LONG_HOLD_CYCLES = 300;

    logic              i_clk;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;
    int                cells_pending;
    int                fail_count;
    bit                sender_calm;
    int unsigned       months_offered;

    mcg_item_if item_bus ();
    mcg_cell_if cell_bus ();

    month_calendar_grid_generator_unit DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (item_bus),
        .o_cell  (cell_bus),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    month_cell_checker CHECK (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .item_bus        (item_bus),
        .cell_bus        (cell_bus),
        .i_psel          (psel),
        .i_penable       (penable),
        .i_pwrite        (pwrite),
        .i_paddr         (paddr),
        .i_pwdata        (pwdata),
        .i_pready        (pready),
        .o_cells_pending (cells_pending),
        .o_fail_count    (fail_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Hard stop in case the block hangs
    initial begin
        #4_000_000;
        $display("FAIL");
        $finish;
    end

    // One register write: setup cycle, then access until pready
    task automatic write_reg(input logic [1:0] idx, input int unsigned value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
    endtask

    // Load the whole grid setup, then release the bus
    task automatic load_grid(input int unsigned ox, input int unsigned oy,
                             input int unsigned cw, input int unsigned ch);
        write_reg(REG_ORIGIN_X, ox);
        write_reg(REG_ORIGIN_Y, oy);
        write_reg(REG_COL_PITCH, cw);
        write_reg(REG_ROW_PITCH, ch);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Offer one month request after a random gap; hold until accepted
    task automatic offer_month(input logic [MONTH_W-1:0] mon,
                               input logic [YEAR_W-1:0]  year,
                               input logic [DAY_W-1:0]   today);
        int unsigned gap;
        if (months_offered % 16 == 0)
            sender_calm = ($urandom_range(0, 3) == 0);
        gap = sender_calm ? 0 : $urandom_range(0, 4);
        months_offered++;
        if (gap > 0) begin
            item_bus.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        item_bus.valid       <= 1'b1;
        item_bus.month_index <= mon;
        item_bus.full_year   <= year;
        item_bus.today_day   <= today;
        do @(posedge i_clk); while (!item_bus.ready);
    endtask

    // Drop valid, wait for every owed cell, then let the date unit drain
    task automatic settle();
        item_bus.valid <= 1'b0;
        do @(posedge i_clk); while (cells_pending != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Cell receiver: random stalls, calm stretches, one long hold-off
    initial begin
        int unsigned stall;
        int unsigned taken;
        bit          calm;
        cell_bus.ready <= 1'b0;
        taken = 0;
        calm  = 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if (taken % 64 == 0)
                calm = ($urandom_range(0, 3) == 0);
            stall = calm ? 0 : $urandom_range(0, 4);
            if (taken == LONG_HOLD_AT)
                stall = LONG_HOLD_CYCLES;
            if (stall > 0) begin
                cell_bus.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            cell_bus.ready <= 1'b1;
            do @(posedge i_clk); while (!cell_bus.valid);
            taken++;
        end
    end

    // Stimulus and verdict
    initial begin
        logic [MONTH_W-1:0] mon;
        logic [YEAR_W-1:0]  year;
        logic [DAY_W-1:0]   today;
        int unsigned        sent;
        i_rst_n              <= 1'b0;
        psel                 <= 1'b0;
        penable              <= 1'b0;
        pwrite               <= 1'b0;
        paddr                <= '0;
        pwdata               <= '0;
        item_bus.valid       <= 1'b0;
        item_bus.month_index <= '0;
        item_bus.full_year   <= '0;
        item_bus.today_day   <= '0;
        months_offered = 0;
        sender_calm    = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: every month of a leap year under the reset grid
        for (int i = 0; i <= MONTH_MAX; i++)
            offer_month(MONTH_W'(i), 14'd2024, DAY_W'((i * 3 + 1) % 32));
        // Leap rule at the century and cycle boundaries
        offer_month(MONTH_FEB, 14'd2023, 5'd28);
        offer_month(MONTH_FEB, 14'd1900, 5'd29);
        offer_month(MONTH_FEB, 14'd2000, 5'd29);
        // Year zero and year one: shift into the year before
        offer_month(MONTH_FEB, 14'd0, 5'd0);
        offer_month(MONTH_JAN, 14'd0, 5'd31);
        offer_month(4'd2, 14'd0, 5'd1);
        offer_month(MONTH_JAN, 14'd1, 5'd1);
        // Top of the year range and beyond it; today past a 30-day month
        offer_month(MONTH_MAX, 14'd9999, 5'd31);
        offer_month(MONTH_FEB, 14'd16383, 5'd31);
        offer_month(MONTH_FEB, 14'd16000, 5'd29);
        offer_month(4'd10, 14'd16383, 5'd31);
        // Month index out of range: consumed, no cells
        offer_month(4'd12, 14'd2024, 5'd5);
        offer_month(4'd15, 14'd16383, 5'd31);
        settle();

        // Random months under several grid setups, extremes first
        for (int phase = 0; phase < RAND_PHASES; phase++) begin
            case (phase)
                0: load_grid(0, 0, 8, 8);
                1: load_grid(255, 255, 63, 63);
                2: load_grid($urandom_range(0, 255), $urandom_range(0, 255),
                             $urandom_range(0, 7), $urandom_range(0, 7));
                default: load_grid($urandom_range(0, 255), $urandom_range(0, 255),
                                   $urandom_range(8, 63), $urandom_range(8, 63));
            endcase
            sent = 0;
            while (sent < MONTHS_PER_PHASE) begin
                if ($urandom_range(0, 19) == 0)
                    mon = MONTH_W'($urandom_range(12, 15));
                else
                    mon = MONTH_W'($urandom_range(0, 11));
                case ($urandom_range(0, 9))
                    0:       year = YEAR_W'($urandom_range(0, 163) * 100);
                    1:       year = YEAR_W'($urandom_range(0, 16383));
                    default: year = YEAR_W'($urandom_range(1, 9999));
                endcase
                if ($urandom_range(0, 15) == 0)
                    today = 5'd0;
                else
                    today = DAY_W'($urandom_range(1, 31));
                offer_month(mon, year, today);
                if (mon <= MONTH_MAX)
                    sent++;
            end
            settle();
        end

        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
